FILE: rtl/slfo_pkg.sv
// ============================================================================
// slfo_pkg
// Shared types, codes and constants of the status LED flash overlay.
// ============================================================================
package slfo_pkg;

    // Timer width default for the top level parameter
    localparam int TIMER_BITS_DEFAULT = 16;

    // Configuration port geometry
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;

    // Item kinds carried on tuser
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Status codes
    localparam logic [2:0] ST_BOOTING     = 3'd0;
    localparam logic [2:0] ST_CONNECTING  = 3'd1;
    localparam logic [2:0] ST_IDLE        = 3'd2;
    localparam logic [2:0] ST_LOW_BATTERY = 3'd3;
    localparam logic [2:0] ST_TAP_OK      = 3'd4;
    localparam logic [2:0] ST_TAP_ERROR   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OK_FLASH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERROR_FLASH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OK_BEEP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERROR_BEEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_PERIOD = 3'd4;

    // Configuration reset values (ticks)
    localparam logic [CFG_W-1:0] OK_FLASH_RST     = 16'd400;
    localparam logic [CFG_W-1:0] ERROR_FLASH_RST  = 16'd600;
    localparam logic [CFG_W-1:0] OK_BEEP_RST      = 16'd80;
    localparam logic [CFG_W-1:0] ERROR_BEEP_RST   = 16'd300;
    localparam logic [CFG_W-1:0] PULSE_PERIOD_RST = 16'd500;

    // LED levels
    localparam logic [7:0] LVL_OFF         = 8'd0;
    localparam logic [7:0] LVL_DIM_WHITE   = 8'd20;
    localparam logic [7:0] LVL_CONNECT     = 8'd60;
    localparam logic [7:0] LVL_BLUE_BRIGHT = 8'd80;
    localparam logic [7:0] LVL_BLUE_DIM    = 8'd15;
    localparam logic [7:0] LVL_WARN_RED    = 8'd200;
    localparam logic [7:0] LVL_WARN_GREEN  = 8'd130;
    localparam logic [7:0] LVL_OK_GREEN    = 8'd180;
    localparam logic [7:0] LVL_ERR_RED     = 8'd200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic       cmd;
        logic [2:0] status_code;
    } item_t;

    typedef struct packed {
        color_t     color;
        logic       buzzer_on;
        logic [2:0] shown_status;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] ok_flash;
        logic [CFG_W-1:0] error_flash;
        logic [CFG_W-1:0] ok_beep;
        logic [CFG_W-1:0] error_beep;
        logic [CFG_W-1:0] pulse_period;
    } cfg_t;

    // Colour shown for a status
    function automatic color_t status_color(input logic [2:0] code);
        color_t c;
        unique case (code)
            ST_BOOTING:     c = '{LVL_DIM_WHITE, LVL_DIM_WHITE, LVL_DIM_WHITE};
            ST_CONNECTING:  c = '{LVL_OFF, LVL_OFF, LVL_CONNECT};
            ST_IDLE:        c = '{LVL_OFF, LVL_OFF, LVL_BLUE_BRIGHT};
            ST_LOW_BATTERY: c = '{LVL_WARN_RED, LVL_WARN_GREEN, LVL_OFF};
            ST_TAP_OK:      c = '{LVL_OFF, LVL_OK_GREEN, LVL_OFF};
            default:        c = '{LVL_ERR_RED, LVL_OFF, LVL_OFF};
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/slfo_cfg_regs.sv
// ============================================================================
// slfo_cfg_regs
// Write-only configuration registers for flash, beep and pulse timing.
// ============================================================================
module slfo_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [slfo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [slfo_pkg::CFG_W-1:0]       cfg_wdata,
    output slfo_pkg::cfg_t                   cfg
);
    import slfo_pkg::*;

    cfg_t cfg_reg;

    // Load the addressed register; drop writes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ok_flash     <= OK_FLASH_RST;
            cfg_reg.error_flash  <= ERROR_FLASH_RST;
            cfg_reg.ok_beep      <= OK_BEEP_RST;
            cfg_reg.error_beep   <= ERROR_BEEP_RST;
            cfg_reg.pulse_period <= PULSE_PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OK_FLASH:     cfg_reg.ok_flash     <= cfg_wdata;
                CFG_ERROR_FLASH:  cfg_reg.error_flash  <= cfg_wdata;
                CFG_OK_BEEP:      cfg_reg.ok_beep      <= cfg_wdata;
                CFG_ERROR_BEEP:   cfg_reg.error_beep   <= cfg_wdata;
                CFG_PULSE_PERIOD: cfg_reg.pulse_period <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/slfo_in_stage.sv
// ============================================================================
// slfo_in_stage
// Input register: captures one transaction per cycle from the slave side while not stalled.
// ============================================================================
module slfo_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [2:0] status_code, [7:3] zero
    input  logic [0:0]      s_tuser,   // [0] cmd
    output logic            item_valid,
    output slfo_pkg::item_t item,
    input  logic            item_ready
);
    import slfo_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new transaction when empty or when the held one moves on
    assign s_tready   = !valid_reg || item_ready;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !item_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd         <= s_tuser[0];
            item_reg.status_code <= s_tdata[2:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/slfo_core.sv
// ============================================================================
// slfo_core
// Status state, flash/beep/pulse timers and LED colour update per item.
// ============================================================================
module slfo_core #(
    parameter int TIMER_BITS = slfo_pkg::TIMER_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  slfo_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  slfo_pkg::item_t   item,
    output logic              item_ready,
    output logic              res_valid,
    output slfo_pkg::result_t res,
    input  logic              res_ready
);
    import slfo_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [2:0]            base_reg, base_next;
    logic [2:0]            shown_reg, shown_next;
    color_t                color_reg, color_next;
    logic [TIMER_BITS-1:0] flash_reg, flash_next;
    logic [TIMER_BITS-1:0] beep_reg, beep_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  bright_reg, bright_next;
    logic                  fire;
    logic                  flash_done;

    // Turn a configured length into a timer load: zero means one tick,
    // saturate at the timer maximum
    function automatic logic [TIMER_BITS-1:0] load_len(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0) ext = CMP_W'(1);
        if (ext > CMP_W'(TMAX)) ext = CMP_W'(TMAX);
        return ext[TIMER_BITS-1:0];
    endfunction

    assign fire       = item_valid && res_ready;
    assign item_ready = res_ready;

    // Next state for one transaction
    always_comb begin
        base_next    = base_reg;
        shown_next   = shown_reg;
        color_next   = color_reg;
        flash_next   = flash_reg;
        beep_next    = beep_reg;
        elapsed_next = elapsed_reg;
        bright_next  = bright_reg;
        flash_done   = 1'b0;
        if (fire) begin
            if (item.cmd == CMD_TICK) begin
                elapsed_next = (elapsed_reg == TMAX) ? elapsed_reg : elapsed_reg + 1'b1;
                if (beep_reg != '0) beep_next = beep_reg - 1'b1;
                // Flash runs out: fall back to the base status
                if (flash_reg != '0) begin
                    flash_next = flash_reg - 1'b1;
                    if (flash_next == '0) begin
                        flash_done = 1'b1;
                        shown_next = base_reg;
                        color_next = status_color(base_reg);
                    end
                end
                // Toggle the connecting blue level each pulse period
                if (!flash_done && shown_reg == ST_CONNECTING &&
                    CMP_W'(elapsed_next) >= CMP_W'(cfg.pulse_period)) begin
                    elapsed_next = '0;
                    bright_next  = !bright_reg;
                    color_next   = '{LVL_OFF, LVL_OFF,
                                     bright_next ? LVL_BLUE_BRIGHT : LVL_BLUE_DIM};
                end
            end else if (item.status_code <= ST_TAP_ERROR) begin
                if (item.status_code <= ST_LOW_BATTERY) base_next = item.status_code;
                shown_next = item.status_code;
                color_next = status_color(item.status_code);
                // Taps restart both timers
                if (item.status_code == ST_TAP_OK) begin
                    flash_next = load_len(cfg.ok_flash);
                    beep_next  = load_len(cfg.ok_beep);
                end else if (item.status_code == ST_TAP_ERROR) begin
                    flash_next = load_len(cfg.error_flash);
                    beep_next  = load_len(cfg.error_beep);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= ST_BOOTING;
            shown_reg   <= ST_BOOTING;
            color_reg   <= '{LVL_DIM_WHITE, LVL_DIM_WHITE, LVL_DIM_WHITE};
            flash_reg   <= '0;
            beep_reg    <= '0;
            elapsed_reg <= '0;
            bright_reg  <= 1'b0;
        end else begin
            base_reg    <= base_next;
            shown_reg   <= shown_next;
            color_reg   <= color_next;
            flash_reg   <= flash_next;
            beep_reg    <= beep_next;
            elapsed_reg <= elapsed_next;
            bright_reg  <= bright_next;
        end
    end

    // Result reflects the state after this transaction
    assign res_valid        = item_valid;
    assign res.color        = color_next;
    assign res.buzzer_on    = (beep_next != '0);
    assign res.shown_status = shown_next;

endmodule

FILE: rtl/slfo_out_stage.sv
// ============================================================================
// slfo_out_stage
// Result register: holds one result until the master side takes it.
// ============================================================================
module slfo_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  slfo_pkg::result_t res,
    output logic              res_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [24] buzzer_on, [27:25] shown_status,
                                        // [31:28] zero
);
    import slfo_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Load when empty or when the held result is taken this cycle
    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.shown_status, res_reg.buzzer_on,
                       res_reg.color.blue, res_reg.color.green, res_reg.color.red};

endmodule

FILE: rtl/status_led_flash_overlay.sv
// ============================================================================
// status_led_flash_overlay
// RGB status LED and buzzer enable driver with timed tap flashes and beeps.
// ============================================================================
//
//  Channel  Ports            Carries
//  -------  ---------------  ---------------------------------------------
//  in       s_tvalid/tready  tuser: cmd; tdata: status_code
//  out      m_tvalid/tready  tdata: red, green, blue, buzzer_on, shown_status
//  config   cfg_we           cfg_addr selects register, cfg_wdata is value
//
//  One transaction per cycle in each direction unless m_tready stalls. The
//  input register takes an item; the state update works on the held item
//  as the result register loads its result, and m_tvalid rises once the
//  result register holds it. The status state and timers update together
//  with the result register load, so items follow back to back. Reset
//  (aresetn low, synchronous) restores booting, dim white and the default
//  timings. A stall on m_tready holds the result register and backs up
//  through the input register to s_tready.
//
module status_led_flash_overlay #(
    parameter int TIMER_BITS = slfo_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [2:0] status_code
    input  logic [0:0]                       s_tuser,   // [0] cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [7:0] red, [15:8] green,
                                                        // [23:16] blue, [24] buzzer_on,
                                                        // [27:25] shown_status
    input  logic                             cfg_we,
    input  logic [slfo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [slfo_pkg::CFG_W-1:0]       cfg_wdata
);
    import slfo_pkg::*;

    cfg_t    cfg;
    logic    item_valid;
    item_t   item;
    logic    item_ready;
    logic    res_valid;
    result_t res;
    logic    res_ready;

    // Timing registers
    slfo_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register
    slfo_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    // State and timer update
    slfo_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Result register
    slfo_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
